@@ rtl/core/swhd_pkg.sv @@
// Package with shared types and constants of the sync word header deframer.
`default_nettype none

package swhd_pkg;

  // Number of message type slots that take part in the compare.
  localparam int unsigned NumTypeSlots = 6;

  // Configuration register indexes.
  localparam int unsigned CfgIdxW        = 3;
  localparam int unsigned CfgDataW       = 32;
  localparam logic [CfgIdxW-1:0] RegSyncWord     = 3'd0;
  localparam logic [CfgIdxW-1:0] RegGarbageLimit = 3'd1;
  localparam logic [CfgIdxW-1:0] RegTypeSlot0    = 3'd2;

  // Reset values of the configuration registers.
  localparam logic [31:0] SyncWordReset     = 32'h4A4F_4B45;
  localparam logic [15:0] GarbageLimitReset = 16'd1024;

  // Field widths of a result transaction.
  localparam int unsigned KindW   = 2;
  localparam int unsigned ByteW   = 8;
  localparam int unsigned TypeIdW = 3;
  localparam int unsigned LenW    = 14;
  localparam int unsigned ErrW    = 2;
  localparam int unsigned OutDataW = 32;

  typedef enum logic [KindW-1:0] {
    KIND_HEADER  = 2'd0,
    KIND_PAYLOAD = 2'd1,
    KIND_ERROR   = 2'd2
  } result_kind_e;

  typedef enum logic [ErrW-1:0] {
    ERR_GARBAGE    = 2'd0,
    ERR_BAD_TYPE   = 2'd1,
    ERR_BAD_LENGTH = 2'd2
  } error_code_e;

  typedef enum logic [2:0] {
    PH_HUNT    = 3'b001,
    PH_HEADER  = 3'b010,
    PH_PAYLOAD = 3'b100
  } phase_e;

  typedef struct packed {
    result_kind_e          kind;
    logic [ByteW-1:0]      payload_byte;
    logic [TypeIdW-1:0]    type_index;
    logic [LenW-1:0]       message_length;
    error_code_e           error_code;
    logic                  last;
  } result_t;

endpackage

`default_nettype wire

@@ rtl/core/sync_word_header_deframer_unit.sv @@
// Sync word header deframer: hunts a sync word, checks type and length, passes payload.
// An accepted byte waits in the input register; its result is then registered for m_axis_tvalid.
// Throughput: one byte per cycle; the input register and the result register form
// a two-stage pipeline that advances whenever the result register is free or drained.
// Reset: rst_ni clears the pipeline, the deframer state (hunting) and the configuration
// registers to their defaults; there is no clearing pass.
`default_nettype none

module sync_word_header_deframer_unit
  import swhd_pkg::*;
(
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  // Configuration write port
  input  wire logic                cfg_we_i,
  input  wire logic [CfgIdxW-1:0]  cfg_idx_i,
  input  wire logic [CfgDataW-1:0] cfg_data_i,
  // Received byte stream
  input  wire logic                s_axis_tvalid,
  output logic                     s_axis_tready,
  input  wire logic [ByteW-1:0]    s_axis_tdata,   // [7:0] rx_byte
  // Result stream
  output logic                     m_axis_tvalid,
  input  wire logic                m_axis_tready,
  // [7:0] payload_byte, [10:8] type_index, [24:11] message_length,
  // [26:25] error_code, [31:27] zero
  output logic [OutDataW-1:0]      m_axis_tdata,
  output logic                     m_axis_tlast,
  output logic [KindW-1:0]         m_axis_tuser    // [1:0] result_kind
);

  // Configuration registers
  logic [31:0] sync_word_q;
  logic [15:0] garbage_limit_q;
  logic [31:0] type_slot_q [NumTypeSlots];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sync_word_q     <= SyncWordReset;
      garbage_limit_q <= GarbageLimitReset;
      for (int i = 0; i < NumTypeSlots; i++) begin
        type_slot_q[i] <= '0;
      end
    end else if (cfg_we_i) begin
      if (cfg_idx_i == RegSyncWord) begin
        sync_word_q <= cfg_data_i;
      end
      if (cfg_idx_i == RegGarbageLimit) begin
        garbage_limit_q <= cfg_data_i[15:0];
      end
      for (int i = 0; i < NumTypeSlots; i++) begin
        if (cfg_idx_i == CfgIdxW'(int'(RegTypeSlot0) + i)) begin
          type_slot_q[i] <= cfg_data_i;
        end
      end
    end
  end

  // Pipeline handshake
  logic             in_valid_q;
  logic [ByteW-1:0] in_byte_q;
  logic             out_valid_q;
  result_t          out_q;
  logic             out_free;
  logic             proc;

  assign out_free      = !out_valid_q || m_axis_tready;
  assign proc          = in_valid_q && out_free;
  assign s_axis_tready = !in_valid_q || out_free;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tready && s_axis_tvalid) begin
      in_byte_q <= s_axis_tdata;
    end
  end

  // Deframer state
  phase_e          phase_q, phase_d;
  logic [31:0]     sync_window_q, sync_window_d;
  logic [2:0]      window_fill_q, window_fill_d;
  logic [15:0]     garbage_count_q, garbage_count_d;
  logic [2:0]      header_index_q, header_index_d;
  logic [31:0]     type_accum_q, type_accum_d;
  logic [LenW-1:0] length_accum_q, length_accum_d;
  logic            digits_ok_q, digits_ok_d;
  logic [LenW-1:0] payload_remaining_q, payload_remaining_d;

  logic                res_valid;
  result_t             res;
  logic [31:0]         window_shift;
  logic [2:0]          fill_inc;
  logic [15:0]         garbage_inc;
  logic                is_digit;
  logic [LenW-1:0]     length_next;
  logic                digits_ok_next;
  logic                type_zero_byte;
  logic                type_found;
  logic [TypeIdW-1:0]  type_hit;

  assign window_shift = {sync_window_q[23:0], in_byte_q};
  assign fill_inc     = (window_fill_q < 3'd4) ? window_fill_q + 3'd1 : window_fill_q;
  assign garbage_inc  = garbage_count_q + 16'd1;
  assign is_digit     = in_byte_q inside {[8'h30:8'h39]};
  // Times ten as two shifts and an add, wrapping at the field width.
  assign length_next  = (length_accum_q << 3) + (length_accum_q << 1)
                      + {{(LenW-4){1'b0}}, in_byte_q[3:0]};
  assign digits_ok_next = digits_ok_q && is_digit;
  assign type_zero_byte = (type_accum_q[31:24] == 8'h00) || (type_accum_q[23:16] == 8'h00) ||
                          (type_accum_q[15:8] == 8'h00) || (type_accum_q[7:0] == 8'h00);

  // The type word is complete once the digits arrive, so the slot compare uses the register.
  always_comb begin
    type_found = 1'b0;
    type_hit   = '0;
    for (int i = NumTypeSlots - 1; i >= 0; i--) begin
      if ((type_slot_q[i] != '0) && (type_slot_q[i] == type_accum_q)) begin
        type_found = 1'b1;
        type_hit   = TypeIdW'(i);
      end
    end
    if (type_zero_byte) begin
      type_found = 1'b0;
    end
  end

  always_comb begin
    phase_d             = phase_q;
    sync_window_d       = sync_window_q;
    window_fill_d       = window_fill_q;
    garbage_count_d     = garbage_count_q;
    header_index_d      = header_index_q;
    type_accum_d        = type_accum_q;
    length_accum_d      = length_accum_q;
    digits_ok_d         = digits_ok_q;
    payload_remaining_d = payload_remaining_q;
    res_valid           = 1'b0;
    res                 = '0;

    if (proc) begin
      case (phase_q)
        PH_HUNT: begin
          if ((fill_inc == 3'd4) && (window_shift == sync_word_q)) begin
            phase_d         = PH_HEADER;
            sync_window_d   = '0;
            window_fill_d   = '0;
            garbage_count_d = '0;
            header_index_d  = '0;
            type_accum_d    = '0;
            length_accum_d  = '0;
            digits_ok_d     = 1'b1;
          end else if (garbage_inc >= garbage_limit_q) begin
            sync_window_d   = '0;
            window_fill_d   = '0;
            garbage_count_d = '0;
            res_valid       = 1'b1;
            res.kind        = KIND_ERROR;
            res.error_code  = ERR_GARBAGE;
          end else begin
            sync_window_d   = window_shift;
            window_fill_d   = fill_inc;
            garbage_count_d = garbage_inc;
          end
        end
        PH_HEADER: begin
          header_index_d = header_index_q + 3'd1;
          if (header_index_q < 3'd4) begin
            type_accum_d = {type_accum_q[23:0], in_byte_q};
          end else begin
            if (is_digit) begin
              length_accum_d = length_next;
            end
            digits_ok_d = digits_ok_next;
            // The fourth length digit closes the header.
            if (header_index_q == 3'd7) begin
              res_valid = 1'b1;
              if (!type_found || !digits_ok_next) begin
                phase_d        = PH_HUNT;
                res.kind       = KIND_ERROR;
                res.error_code = type_found ? ERR_BAD_LENGTH : ERR_BAD_TYPE;
              end else if (length_next == '0) begin
                phase_d        = PH_HUNT;
                res.kind       = KIND_HEADER;
                res.type_index = type_hit;
                res.last       = 1'b1;
              end else begin
                phase_d             = PH_PAYLOAD;
                payload_remaining_d = length_next;
                res.kind            = KIND_HEADER;
                res.type_index      = type_hit;
                res.message_length  = length_next;
              end
            end
          end
        end
        PH_PAYLOAD: begin
          res_valid        = 1'b1;
          res.kind         = KIND_PAYLOAD;
          res.payload_byte = in_byte_q;
          if (payload_remaining_q <= LenW'(1)) begin
            payload_remaining_d = '0;
            res.last            = 1'b1;
            phase_d             = PH_HUNT;
          end else begin
            payload_remaining_d = payload_remaining_q - LenW'(1);
          end
        end
        default: begin
          phase_d         = PH_HUNT;
          sync_window_d   = '0;
          window_fill_d   = '0;
          garbage_count_d = '0;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q             <= PH_HUNT;
      sync_window_q       <= '0;
      window_fill_q       <= '0;
      garbage_count_q     <= '0;
      header_index_q      <= '0;
      type_accum_q        <= '0;
      length_accum_q      <= '0;
      digits_ok_q         <= 1'b1;
      payload_remaining_q <= '0;
      out_valid_q         <= 1'b0;
    end else begin
      phase_q             <= phase_d;
      sync_window_q       <= sync_window_d;
      window_fill_q       <= window_fill_d;
      garbage_count_q     <= garbage_count_d;
      header_index_q      <= header_index_d;
      type_accum_q        <= type_accum_d;
      length_accum_q      <= length_accum_d;
      digits_ok_q         <= digits_ok_d;
      payload_remaining_q <= payload_remaining_d;
      if (out_free) begin
        out_valid_q <= proc && res_valid;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (proc && res_valid) begin
      out_q <= res;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {{(OutDataW - ByteW - TypeIdW - LenW - ErrW){1'b0}},
                          out_q.error_code, out_q.message_length,
                          out_q.type_index, out_q.payload_byte};
  assign m_axis_tlast  = out_q.last;
  assign m_axis_tuser  = out_q.kind;

  // Payload phase always has bytes left to pass.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q == PH_PAYLOAD) |-> (payload_remaining_q != '0))
    else $error("payload phase entered with nothing left");

  // Any error sends the deframer back to hunting.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (proc && res_valid && (res.kind == KIND_ERROR)) |=> (phase_q == PH_HUNT))
    else $error("error did not restart the sync hunt");

  // Error transactions never mark the end of a message.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && (out_q.kind == KIND_ERROR)) |-> !m_axis_tlast)
    else $error("error transaction carries tlast");

  // A header marks the message end exactly when its length is zero.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && (out_q.kind == KIND_HEADER)) |->
      (m_axis_tlast == (out_q.message_length == '0)))
    else $error("header tlast disagrees with its length");

  // A byte is only processed in the cycle after it was accepted or while it was held.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid && s_axis_tready) |=> in_valid_q)
    else $error("accepted byte lost from the input register");

endmodule

`default_nettype wire

@@ tb/sync_word_header_deframer_unit_tb.sv @@
// Self-checking testbench for the sync word header deframer with a byte-level deframing predictor.
`timescale 1ns / 1ps

module sync_word_header_deframer_unit_tb;
  import swhd_pkg::*;

  localparam int unsigned CycleLimit = 1_000_000;
  localparam int unsigned NumSegments = 8;
  // Slot contents of the first segment, slot 0 in the lowest word.
  localparam logic [6*32-1:0] DirectedSlots = {32'hFFFF_FFFF, 32'h4100_4243, 32'h5459_5041,
                                               32'h5459_5042, 32'h5459_5041, 32'h0000_0000};

  logic                clk_i = 1'b0;
  logic                rst_ni = 1'b0;
  logic                cfg_we_i = 1'b0;
  logic [CfgIdxW-1:0]  cfg_idx_i = '0;
  logic [CfgDataW-1:0] cfg_data_i = '0;
  logic                s_axis_tvalid = 1'b0;
  logic                s_axis_tready;
  logic [ByteW-1:0]    s_axis_tdata = '0;   // [7:0] rx_byte
  logic                m_axis_tvalid;
  logic                m_axis_tready = 1'b0;
  // [7:0] payload_byte, [10:8] type_index, [24:11] message_length, [26:25] error_code
  logic [OutDataW-1:0] m_axis_tdata;
  logic                m_axis_tlast;
  logic [KindW-1:0]    m_axis_tuser;        // [1:0] result_kind

  sync_word_header_deframer_unit u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .m_axis_tuser  (m_axis_tuser)
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  // Configuration as the block holds it.
  logic [31:0] sync_word_cfg = SyncWordReset;
  logic [15:0] garbage_limit_cfg = GarbageLimitReset;
  logic [31:0] type_slot_cfg [NumTypeSlots] = '{default: '0};

  // Deframer state mirrored by the predictor.
  phase_e          deframe_phase = PH_HUNT;
  logic [31:0]     sync_window = '0;
  logic [2:0]      window_fill = '0;
  logic [15:0]     garbage_count = '0;
  logic [2:0]      header_idx = '0;
  logic [31:0]     type_accum = '0;
  logic [LenW-1:0] length_accum = '0;
  logic            digits_ok = 1'b1;
  logic [LenW-1:0] payload_left = '0;

  logic [7:0]  rx_bytes_pending [$];
  result_t     deframed_due [$];
  result_t     predicted;
  result_t     oldest;
  int unsigned src_idle_pct = 0;
  int unsigned sink_stall_pct = 0;
  int unsigned mismatches = 0;
  int unsigned cycle_count = 0;

  function automatic void restart_hunt();
    deframe_phase = PH_HUNT;
    sync_window = '0;
    window_fill = '0;
    garbage_count = '0;
  endfunction

  // Advances the mirrored state by one received byte; returns 1 when a result is due.
  function automatic bit deframe_byte(input logic [7:0] b, output result_t r);
    bit got;
    bit found;
    logic [TypeIdW-1:0] hit;
    got = 1'b0;
    found = 1'b0;
    hit = '0;
    r = '0;
    case (deframe_phase)
      PH_HUNT: begin
        sync_window = {sync_window[23:0], b};
        if (window_fill < 3'd4) window_fill = window_fill + 3'd1;
        if (window_fill == 3'd4 && sync_window == sync_word_cfg) begin
          restart_hunt();
          deframe_phase = PH_HEADER;
          header_idx = '0;
          type_accum = '0;
          length_accum = '0;
          digits_ok = 1'b1;
        end else begin
          garbage_count = garbage_count + 16'd1;
          if (garbage_count >= garbage_limit_cfg) begin
            restart_hunt();
            r.kind = KIND_ERROR;
            r.error_code = ERR_GARBAGE;
            got = 1'b1;
          end
        end
      end
      PH_HEADER: begin
        if (header_idx < 3'd4) begin
          type_accum = {type_accum[23:0], b};
          header_idx = header_idx + 3'd1;
        end else begin
          if (b >= 8'h30 && b <= 8'h39) begin
            length_accum = LenW'(length_accum * 10 + (b - 8'h30));
          end else begin
            digits_ok = 1'b0;
          end
          header_idx = header_idx + 3'd1;
          // The index wraps to zero on the fourth length digit.
          if (header_idx == 3'd0) begin
            got = 1'b1;
            if (type_accum[31:24] != 8'h00 && type_accum[23:16] != 8'h00 &&
                type_accum[15:8] != 8'h00 && type_accum[7:0] != 8'h00) begin
              for (int i = 0; i < NumTypeSlots; i++) begin
                if (!found && type_slot_cfg[i] != '0 && type_slot_cfg[i] == type_accum) begin
                  found = 1'b1;
                  hit = TypeIdW'(i);
                end
              end
            end
            if (!found) begin
              restart_hunt();
              r.kind = KIND_ERROR;
              r.error_code = ERR_BAD_TYPE;
            end else if (!digits_ok) begin
              restart_hunt();
              r.kind = KIND_ERROR;
              r.error_code = ERR_BAD_LENGTH;
            end else begin
              r.kind = KIND_HEADER;
              r.type_index = hit;
              r.message_length = length_accum;
              if (length_accum == '0) begin
                restart_hunt();
                r.last = 1'b1;
              end else begin
                payload_left = length_accum;
                deframe_phase = PH_PAYLOAD;
              end
            end
          end
        end
      end
      default: begin
        got = 1'b1;
        r.kind = KIND_PAYLOAD;
        r.payload_byte = b;
        if (payload_left <= 1) begin
          payload_left = '0;
          r.last = 1'b1;
          restart_hunt();
        end else begin
          payload_left = payload_left - 1'b1;
        end
      end
    endcase
    return got;
  endfunction

  function automatic void check_field(input string name, input logic [31:0] want_v,
                                      input logic [31:0] got_v);
    if (got_v !== want_v) begin
      $error("%s: expected 0x%0h, actual 0x%0h", name, want_v, got_v);
      mismatches++;
    end
  endfunction

  // Byte source: predicts on every accepted transaction, then offers the next byte.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (s_axis_tvalid && s_axis_tready) begin
        if (deframe_byte(s_axis_tdata, predicted)) deframed_due.push_back(predicted);
      end
      if (!s_axis_tvalid || s_axis_tready) begin
        if (rx_bytes_pending.size() != 0 && $urandom_range(99) >= src_idle_pct) begin
          s_axis_tvalid <= 1'b1;
          s_axis_tdata <= rx_bytes_pending.pop_front();
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  // Result sink: compares each accepted transaction with the oldest prediction.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (m_axis_tvalid && m_axis_tready) begin
        if (deframed_due.size() == 0) begin
          $error("result with none expected: tuser 0x%0h, tdata 0x%0h", m_axis_tuser,
                 m_axis_tdata);
          mismatches++;
        end else begin
          oldest = deframed_due.pop_front();
          check_field("result_kind", oldest.kind, m_axis_tuser);
          check_field("payload_byte", oldest.payload_byte, m_axis_tdata[7:0]);
          check_field("type_index", oldest.type_index, m_axis_tdata[10:8]);
          check_field("message_length", oldest.message_length, m_axis_tdata[24:11]);
          check_field("error_code", oldest.error_code, m_axis_tdata[26:25]);
          check_field("tdata padding", '0, m_axis_tdata[31:27]);
          check_field("last", oldest.last, m_axis_tlast);
        end
      end
      m_axis_tready <= ($urandom_range(99) >= sink_stall_pct);
    end
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CycleLimit) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [31:0] val);
    @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= val;
    if (idx == RegSyncWord) begin
      sync_word_cfg = val;
    end else if (idx == RegGarbageLimit) begin
      garbage_limit_cfg = val[15:0];
    end else begin
      type_slot_cfg[idx - RegTypeSlot0] = val;
    end
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  // Queues sync word, type word, four length digits (one spoiled if asked) and payload.
  task automatic push_frame(input logic [31:0] type_word, input int unsigned len,
                            input bit bad_digit, input int unsigned n_payload);
    int unsigned bad_pos;
    int unsigned scale;
    logic [7:0] d;
    bad_pos = $urandom_range(3);
    scale = 1000;
    for (int k = 3; k >= 0; k--) rx_bytes_pending.push_back(sync_word_cfg[8*k +: 8]);
    for (int k = 3; k >= 0; k--) rx_bytes_pending.push_back(type_word[8*k +: 8]);
    for (int k = 0; k < 4; k++) begin
      d = 8'h30 + 8'((len / scale) % 10);
      if (bad_digit && k == bad_pos) begin
        d = 8'($urandom_range(255));
        if (d >= 8'h30 && d <= 8'h39) d = d ^ 8'h40;
      end
      rx_bytes_pending.push_back(d);
      scale = scale / 10;
    end
    for (int k = 0; k < n_payload; k++) rx_bytes_pending.push_back(8'($urandom_range(255)));
  endtask

  initial begin : stimulus
    int unsigned seg;
    int unsigned pick;
    int unsigned len;
    int unsigned target;
    logic [31:0] tw;
    logic [31:0] val;
    logic [31:0] good_types [$];

    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;

    for (seg = 0; seg < NumSegments; seg++) begin
      case (seg / 2)
        0: begin src_idle_pct <= 0;  sink_stall_pct <= 0;  end
        1: begin src_idle_pct <= 72; sink_stall_pct <= 0;  end
        2: begin src_idle_pct <= 0;  sink_stall_pct <= 72; end
        default: begin src_idle_pct <= 17; sink_stall_pct <= 17; end
      endcase

      case (seg)
        0: val = SyncWordReset;
        2: val = '1;
        3: val = '0;
        default: val = $urandom();
      endcase
      write_reg(RegSyncWord, val);
      case (seg)
        0: val = 32'd4;
        1: val = 32'd1024;
        2: val = 32'd65535;
        3: val = 32'd0;
        4: val = 32'd1;
        default: val = $urandom_range(16, 4000);
      endcase
      write_reg(RegGarbageLimit, val);
      for (int i = 0; i < NumTypeSlots; i++) begin
        if (seg == 0) begin
          val = DirectedSlots[32*i +: 32];
        end else if ($urandom_range(3) == 0) begin
          val = '0;
        end else begin
          val = {8'($urandom_range(1, 255)), 8'($urandom_range(1, 255)),
                 8'($urandom_range(1, 255)), 8'($urandom_range(1, 255))};
        end
        if (seg == 2 && i == NumTypeSlots - 1) val = '1;
        write_reg(RegTypeSlot0 + CfgIdxW'(i), val);
      end

      good_types.delete();
      for (int i = 0; i < NumTypeSlots; i++) begin
        if (type_slot_cfg[i][31:24] != 8'h00 && type_slot_cfg[i][23:16] != 8'h00 &&
            type_slot_cfg[i][15:8] != 8'h00 && type_slot_cfg[i][7:0] != 8'h00)
          good_types.push_back(type_slot_cfg[i]);
      end
      @(posedge clk_i);

      if (seg == 0) begin
        // Garbage count hits the limit of four on the fourth byte, so a fresh
        // sync must then succeed with three counted bytes and an uncounted fourth.
        rx_bytes_pending.push_back(8'h00);
        rx_bytes_pending.push_back(8'hFF);
        rx_bytes_pending.push_back(8'h00);
        rx_bytes_pending.push_back(SyncWordReset[31:24]);
        // Zero length on a type held in two slots: the lower slot is reported.
        push_frame(32'h5459_5041, 0, 1'b0, 0);
        // A type with a zero byte never matches, and bad type wins over bad digits.
        push_frame(32'h4100_4243, 12, 1'b1, 0);
      end

      target = (seg == 3 || seg == 4) ? 30 : 125;
      while (rx_bytes_pending.size() < target) begin
        pick = (seg == 3 || seg == 4) ? 0 : $urandom_range(99);
        if (good_types.size() != 0) begin
          tw = good_types[$urandom_range(good_types.size() - 1)];
        end else begin
          tw = $urandom();
        end
        if (pick < 10) begin
          if ($urandom_range(1) == 0) begin
            // Partial sync word followed by noise.
            len = $urandom_range(3);
            for (int j = 0; j < len; j++)
              rx_bytes_pending.push_back(sync_word_cfg[8*(3-j) +: 8]);
          end else if (seg != 3 && seg != 4) begin
            // Sync followed by a truncated header.
            for (int k = 3; k >= 0; k--) rx_bytes_pending.push_back(sync_word_cfg[8*k +: 8]);
          end
          len = $urandom_range(1, 20);
          for (int j = 0; j < len; j++) rx_bytes_pending.push_back(8'($urandom_range(255)));
        end else if (pick < 20) begin
          tw = $urandom();
          if ($urandom_range(1) == 0) tw[8*$urandom_range(3) +: 8] = 8'h00;
          push_frame(tw, $urandom_range(9999), $urandom_range(3) == 0, 0);
        end else if (pick < 30) begin
          push_frame(tw, $urandom_range(9999), 1'b1, 0);
        end else if (pick < 40) begin
          push_frame(tw, 0, 1'b0, 0);
        end else begin
          len = ($urandom_range(19) == 0) ? $urandom_range(13, 300) : $urandom_range(1, 12);
          push_frame(tw, len, 1'b0, len);
        end
      end

      // All-nines length digits behind a type that never matches, so no payload follows.
      if (seg == 0) push_frame(32'h4100_4243, 9999, 1'b0, 0);

      while (rx_bytes_pending.size() != 0 || s_axis_tvalid || deframed_due.size() != 0)
        @(posedge clk_i);
      // Bytes that give no result may still be in the pipeline.
      repeat (8) @(posedge clk_i);
    end

    if (mismatches == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
